[rtl/pbfi_pkg.sv]
// ----------------------------------------------------------------------------
// pbfi_pkg
// Shared types and constants of the partitioned bitmap filter insert block.
// ----------------------------------------------------------------------------
package pbfi_pkg;

    // configuration register indexes
    localparam int CFG_INDEX_W = 1;
    localparam int CFG_DATA_W  = 5;
    localparam logic [CFG_INDEX_W-1:0] REG_REGION_MODE = 1'b0;
    localparam logic [CFG_INDEX_W-1:0] REG_REGION_SIZE = 1'b1;

    // region mode codes, the unused code behaves as eight regions
    localparam logic [1:0] MODE_ONE   = 2'd0;
    localparam logic [1:0] MODE_FOUR  = 2'd1;
    localparam logic [1:0] MODE_EIGHT = 2'd2;

    localparam logic [1:0] MODE_RESET = MODE_FOUR;
    localparam logic [4:0] SIZE_RESET = 5'd15;
    localparam logic [4:0] SIZE_MIN   = 5'd5;

    // commands
    localparam logic CMD_INSERT = 1'b0;
    localparam logic CMD_READ   = 1'b1;

    localparam logic [31:0] HALF_MASK = 32'h0000ffff;
    localparam int          HALF_W    = 16;

    localparam int MAX_REGIONS = 8;
    localparam int REGION_W    = 3;
    // widest word address, for the largest bitmap the block supports
    localparam int ADDR_W_MAX  = 21;
    localparam int BIT_W       = 5;

    localparam int QUEUE_DEPTH = 2;

    typedef logic [ADDR_W_MAX-1:0] t_word_addr;

    // one classified item: word and bit of every region it touches
    typedef struct packed {
        logic                                  cmd;
        logic [REGION_W-1:0]                   last;
        t_word_addr [MAX_REGIONS-1:0]          addr;
        logic [MAX_REGIONS-1:0][BIT_W-1:0]     bitpos;
    } t_entry;

    typedef enum logic [2:0] {
        BK_CLEAR,
        BK_IDLE,
        BK_ISSUE,
        BK_DRAIN,
        BK_DONE
    } t_bk_state;

endpackage

[rtl/pbfi_in_if.sv]
// ----------------------------------------------------------------------------
// pbfi_in_if
// Input channel: command, 128-bit hash and read word address.
// ----------------------------------------------------------------------------
interface pbfi_in_if;
    logic        valid;
    logic        ready;
    logic        command;
    logic [31:0] hash_word0;
    logic [31:0] hash_word1;
    logic [31:0] hash_word2;
    logic [31:0] hash_word3;
    logic [14:0] word_address;

    modport source (
        output valid, command, hash_word0, hash_word1, hash_word2, hash_word3,
               word_address,
        input  ready
    );
    modport sink (
        input  valid, command, hash_word0, hash_word1, hash_word2, hash_word3,
               word_address,
        output ready
    );
endinterface

[rtl/pbfi_out_if.sv]
// ----------------------------------------------------------------------------
// pbfi_out_if
// Result channel: bitmap word for reads, presence flag for inserts.
// ----------------------------------------------------------------------------
interface pbfi_out_if;
    logic        valid;
    logic        ready;
    logic [31:0] read_data;
    logic        was_present;

    modport source (
        output valid, read_data, was_present,
        input  ready
    );
    modport sink (
        input  valid, read_data, was_present,
        output ready
    );
endinterface

[rtl/pbfi_ram.sv]
// ----------------------------------------------------------------------------
// pbfi_ram
// Generic single write port, single read port RAM with registered read.
// ----------------------------------------------------------------------------
module pbfi_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

[rtl/pbfi_front.sv]
// ----------------------------------------------------------------------------
// pbfi_front
// Holds the configuration and turns each accepted item into region word
// addresses and bit positions for the back end.
// ----------------------------------------------------------------------------
module pbfi_front #(
    parameter int TOTAL_BITS_LOG2 = 20
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_cfg_we,
    input  logic [pbfi_pkg::CFG_INDEX_W-1:0]   i_cfg_index,
    input  logic [pbfi_pkg::CFG_DATA_W-1:0]    i_cfg_data,
    pbfi_in_if.sink                            i_item,
    input  logic                               i_queue_full,
    input  logic                               i_clearing,
    output logic                               o_push,
    output pbfi_pkg::t_entry                   o_entry
);

    localparam logic [4:0] TOTAL_LOG2 = 5'(TOTAL_BITS_LOG2);

    logic [1:0] r_mode;
    logic [4:0] r_size;

    logic [1:0]  cnt_log2;
    logic [4:0]  size_top;
    logic [4:0]  size_clamp;
    logic [4:0]  size_eff;
    logic [4:0]  stride_sh;
    logic [31:0] idx_mask;
    logic [pbfi_pkg::REGION_W-1:0] last_region;
    logic [31:0] src [pbfi_pkg::MAX_REGIONS];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= pbfi_pkg::MODE_RESET;
            r_size <= pbfi_pkg::SIZE_RESET;
        end else if (i_cfg_we) begin
            if (i_cfg_index == pbfi_pkg::REG_REGION_MODE) begin
                r_mode <= i_cfg_data[1:0];
            end else begin
                r_size <= i_cfg_data;
            end
        end
    end

    assign i_item.ready = !i_queue_full && !i_clearing;
    assign o_push       = i_item.valid && i_item.ready;

    // region count and clamped region size
    always_comb begin
        case (r_mode)
            pbfi_pkg::MODE_ONE: begin
                cnt_log2    = 2'd0;
                last_region = 3'd0;
            end
            pbfi_pkg::MODE_FOUR: begin
                cnt_log2    = 2'd2;
                last_region = 3'd3;
            end
            default: begin
                cnt_log2    = 2'd3;
                last_region = 3'd7;
            end
        endcase
        size_top   = TOTAL_LOG2 - {3'b000, cnt_log2};
        size_clamp = (r_size > size_top) ? size_top : r_size;
        size_eff   = (size_clamp < pbfi_pkg::SIZE_MIN) ? pbfi_pkg::SIZE_MIN : size_clamp;
        stride_sh  = size_eff - pbfi_pkg::SIZE_MIN;
        idx_mask   = ~(32'hffffffff << size_eff);
    end

    // hash words to region sources
    always_comb begin
        for (int r = 0; r < pbfi_pkg::MAX_REGIONS; r++) begin
            src[r] = 32'd0;
        end
        case (r_mode)
            pbfi_pkg::MODE_ONE: begin
                src[0] = i_item.hash_word3;
            end
            pbfi_pkg::MODE_FOUR: begin
                src[0] = i_item.hash_word3;
                src[1] = i_item.hash_word2;
                src[2] = i_item.hash_word1;
                src[3] = i_item.hash_word0;
            end
            default: begin
                src[0] = i_item.hash_word0 & pbfi_pkg::HALF_MASK;
                src[1] = i_item.hash_word0 >> pbfi_pkg::HALF_W;
                src[2] = i_item.hash_word1 & pbfi_pkg::HALF_MASK;
                src[3] = i_item.hash_word1 >> pbfi_pkg::HALF_W;
                src[4] = i_item.hash_word2 & pbfi_pkg::HALF_MASK;
                src[5] = i_item.hash_word2 >> pbfi_pkg::HALF_W;
                src[6] = i_item.hash_word3 & pbfi_pkg::HALF_MASK;
                src[7] = i_item.hash_word3 >> pbfi_pkg::HALF_W;
            end
        endcase
    end

    // per region: word = region * stride + index / 32, bit = index % 32
    always_comb begin
        logic [31:0] idx;
        logic [26:0] region_off;
        logic [26:0] word_sel;
        o_entry.cmd  = i_item.command;
        o_entry.last = (i_item.command == pbfi_pkg::CMD_READ) ? 3'd0 : last_region;
        for (int r = 0; r < pbfi_pkg::MAX_REGIONS; r++) begin
            idx        = src[r] & idx_mask;
            region_off = 27'(r) << stride_sh;
            word_sel   = 27'(idx >> 5);
            o_entry.addr[r]   = pbfi_pkg::ADDR_W_MAX'(region_off + word_sel);
            o_entry.bitpos[r] = idx[pbfi_pkg::BIT_W-1:0];
        end
        if (i_item.command == pbfi_pkg::CMD_READ) begin
            o_entry.addr[0] = pbfi_pkg::ADDR_W_MAX'(i_item.word_address);
        end
    end

endmodule

[rtl/pbfi_queue.sv]
// ----------------------------------------------------------------------------
// pbfi_queue
// Short queue of classified items between front and back end.
// ----------------------------------------------------------------------------
module pbfi_queue (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  pbfi_pkg::t_entry i_entry,
    input  logic             i_pop,
    output pbfi_pkg::t_entry o_entry,
    output logic             o_empty,
    output logic             o_full
);

    localparam int PTR_W = $clog2(pbfi_pkg::QUEUE_DEPTH);
    localparam int CNT_W = $clog2(pbfi_pkg::QUEUE_DEPTH + 1);

    pbfi_pkg::t_entry r_mem [pbfi_pkg::QUEUE_DEPTH];
    logic [PTR_W-1:0] r_wp;
    logic [PTR_W-1:0] r_rp;
    logic [CNT_W-1:0] r_cnt;

    assign o_empty = (r_cnt == '0);
    assign o_full  = (r_cnt == CNT_W'(pbfi_pkg::QUEUE_DEPTH));
    assign o_entry = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wp] <= i_entry;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wp <= PTR_W'((32'(r_wp) + 1) % pbfi_pkg::QUEUE_DEPTH);
            end
            if (i_pop) begin
                r_rp <= PTR_W'((32'(r_rp) + 1) % pbfi_pkg::QUEUE_DEPTH);
            end
            case ({i_push, i_pop})
                2'b10:   r_cnt <= r_cnt + 1'b1;
                2'b01:   r_cnt <= r_cnt - 1'b1;
                default: r_cnt <= r_cnt;
            endcase
        end
    end

endmodule

[rtl/pbfi_back.sv]
// ----------------------------------------------------------------------------
// pbfi_back
// Clears the bitmap after reset; runs one read-modify-write per region of each
// queued insert (one plain read for a read item), result via output register.
// ----------------------------------------------------------------------------
module pbfi_back #(
    parameter int TOTAL_BITS_LOG2 = 20
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  pbfi_pkg::t_entry i_entry,
    input  logic             i_empty,
    output logic             o_pop,
    output logic             o_clearing,
    pbfi_out_if.source       o_result
);

    localparam int AW    = TOTAL_BITS_LOG2 - 5;
    localparam int DEPTH = 1 << AW;

    pbfi_pkg::t_bk_state r_state, n_state;

    pbfi_pkg::t_entry              r_ent;
    logic [pbfi_pkg::REGION_W-1:0] r_k;
    logic                          r_pend;
    logic [AW-1:0]                 r_pend_addr;
    logic [pbfi_pkg::BIT_W-1:0]    r_pend_bit;
    logic                          r_all_set;
    logic [AW-1:0]                 r_clr_addr;
    logic [31:0]                   r_res_data;
    logic                          r_res_present;
    logic                          r_out_valid;
    logic [31:0]                   r_out_data;
    logic                          r_out_present;

    logic          ram_we;
    logic [AW-1:0] ram_waddr;
    logic [31:0]   ram_wdata;
    logic [AW-1:0] ram_raddr;
    logic [31:0]   ram_rdata;

    logic [31:0] bit_onehot;
    logic        bit_hit;
    logic        n_all_set;
    logic        issue;
    logic        out_free;
    logic        load_out;

    pbfi_ram #(
        .WIDTH (32),
        .DEPTH (DEPTH)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    assign bit_onehot = 32'h1 << r_pend_bit;
    assign bit_hit    = (ram_rdata & bit_onehot) != 32'd0;
    assign n_all_set  = r_pend ? (r_all_set && bit_hit) : r_all_set;
    assign out_free   = !r_out_valid || o_result.ready;

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            pbfi_pkg::BK_CLEAR: begin
                if (&r_clr_addr) begin
                    n_state = pbfi_pkg::BK_IDLE;
                end
            end
            pbfi_pkg::BK_IDLE: begin
                if (!i_empty) begin
                    n_state = pbfi_pkg::BK_ISSUE;
                end
            end
            pbfi_pkg::BK_ISSUE: begin
                if (r_k == r_ent.last) begin
                    n_state = pbfi_pkg::BK_DRAIN;
                end
            end
            pbfi_pkg::BK_DRAIN: begin
                n_state = pbfi_pkg::BK_DONE;
            end
            pbfi_pkg::BK_DONE: begin
                if (out_free) begin
                    n_state = pbfi_pkg::BK_IDLE;
                end
            end
            default: begin
                n_state = pbfi_pkg::BK_IDLE;
            end
        endcase
    end

    // outputs of the sequencer
    always_comb begin
        o_pop      = 1'b0;
        o_clearing = 1'b0;
        issue      = 1'b0;
        load_out   = 1'b0;
        ram_we     = 1'b0;
        ram_waddr  = r_pend_addr;
        ram_wdata  = ram_rdata | bit_onehot;
        ram_raddr  = r_ent.addr[r_k][AW-1:0];
        case (r_state)
            pbfi_pkg::BK_CLEAR: begin
                o_clearing = 1'b1;
                ram_we     = 1'b1;
                ram_waddr  = r_clr_addr;
                ram_wdata  = 32'd0;
            end
            pbfi_pkg::BK_IDLE: begin
                o_pop = !i_empty;
            end
            pbfi_pkg::BK_ISSUE: begin
                issue = 1'b1;
            end
            pbfi_pkg::BK_DONE: begin
                load_out = out_free;
            end
            default: begin
                issue = 1'b0;
            end
        endcase
        // write back the word read in the previous cycle
        if (r_pend && r_ent.cmd == pbfi_pkg::CMD_INSERT) begin
            ram_we = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= pbfi_pkg::BK_CLEAR;
            r_clr_addr  <= '0;
            r_pend      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (r_state == pbfi_pkg::BK_CLEAR) begin
                r_clr_addr <= r_clr_addr + 1'b1;
            end
            r_pend <= issue;
            if (load_out) begin
                r_out_valid <= 1'b1;
            end else if (o_result.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_ent     <= i_entry;
            r_k       <= '0;
            r_all_set <= 1'b1;
        end else begin
            r_all_set <= n_all_set;
            if (issue) begin
                r_k <= r_k + 1'b1;
            end
        end
        if (issue) begin
            r_pend_addr <= r_ent.addr[r_k][AW-1:0];
            r_pend_bit  <= r_ent.bitpos[r_k];
        end
        if (r_state == pbfi_pkg::BK_DRAIN) begin
            if (r_ent.cmd == pbfi_pkg::CMD_READ) begin
                r_res_data    <= ram_rdata;
                r_res_present <= 1'b0;
            end else begin
                r_res_data    <= 32'd0;
                r_res_present <= n_all_set;
            end
        end
        if (load_out) begin
            r_out_data    <= r_res_data;
            r_out_present <= r_res_present;
        end
    end

    assign o_result.valid       = r_out_valid;
    assign o_result.read_data   = r_out_data;
    assign o_result.was_present = r_out_present;

endmodule

[rtl/partitioned_bitmap_filter_insert.sv]
// an insert goes from queue to output register through ISSUE, once per region, then DRAIN and DONE
// a read issues a single word; one item is in the back end at a time, one region per cycle
// set by the single write port of the bitmap ram; a two entry queue buffers the front
// reset is synchronous; afterwards the bitmap is cleared one word per cycle, all
// 2^(TOTAL_BITS_LOG2-5) words, during which no item is accepted (config writes are)
// ----------------------------------------------------------------------------
// partitioned_bitmap_filter_insert
// Partitioned bloom filter bitmap: inserts 128-bit hashes, reads back words.
// ----------------------------------------------------------------------------
module partitioned_bitmap_filter_insert #(
    parameter int TOTAL_BITS_LOG2 = 20
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_cfg_we,
    input  logic [pbfi_pkg::CFG_INDEX_W-1:0] i_cfg_index,
    input  logic [pbfi_pkg::CFG_DATA_W-1:0]  i_cfg_data,
    pbfi_in_if.sink                          i_item,
    pbfi_out_if.source                       o_result
);

    pbfi_pkg::t_entry push_entry;
    pbfi_pkg::t_entry head_entry;
    logic             push;
    logic             pop;
    logic             q_empty;
    logic             q_full;
    logic             clearing;

    pbfi_front #(
        .TOTAL_BITS_LOG2 (TOTAL_BITS_LOG2)
    ) u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data),
        .i_item       (i_item),
        .i_queue_full (q_full),
        .i_clearing   (clearing),
        .o_push       (push),
        .o_entry      (push_entry)
    );

    pbfi_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_entry (push_entry),
        .i_pop   (pop),
        .o_entry (head_entry),
        .o_empty (q_empty),
        .o_full  (q_full)
    );

    pbfi_back #(
        .TOTAL_BITS_LOG2 (TOTAL_BITS_LOG2)
    ) u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_entry    (head_entry),
        .i_empty    (q_empty),
        .o_pop      (pop),
        .o_clearing (clearing),
        .o_result   (o_result)
    );

endmodule

[rtl/pbfi_checker.sv]
// ----------------------------------------------------------------------------
// pbfi_checker
// Port level checks of the partitioned bitmap filter insert block.
// ----------------------------------------------------------------------------
module pbfi_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_in_ready,
    input logic        i_out_valid,
    input logic        i_out_ready,
    input logic [31:0] i_out_read_data,
    input logic        i_out_was_present
);

    // a stalled result stays offered
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid)
        else $error("result dropped while stalled");

    a_out_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=>
            $stable(i_out_read_data) && $stable(i_out_was_present))
        else $error("result payload changed while stalled");

    // a result with nonzero read data never reports presence
    a_result_kind: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_out_read_data != 32'd0 |-> !i_out_was_present)
        else $error("result carries both data and presence");

    // no result right after reset
    a_reset_out: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid)
        else $error("result valid after reset");

    // bitmap clearing holds off items after reset
    a_reset_clear: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_in_ready)
        else $error("item accepted before bitmap clear");

endmodule

bind partitioned_bitmap_filter_insert pbfi_checker u_pbfi_checker (
    .i_clk             (i_clk),
    .i_rst_n           (i_rst_n),
    .i_in_ready        (i_item.ready),
    .i_out_valid       (o_result.valid),
    .i_out_ready       (o_result.ready),
    .i_out_read_data   (o_result.read_data),
    .i_out_was_present (o_result.was_present)
);

[test/testbench.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Drives insert and read items into the partitioned bitmap filter and checks
// every result against a shadow bitmap kept in step with the accepted items.
// ----------------------------------------------------------------------------
module testbench;

    localparam int TOTAL_LOG2 = 20;
    localparam int WORDS      = 1 << (TOTAL_LOG2 - pbfi_pkg::BIT_W);
    localparam int LONG_HOLD  = 300;
    localparam int HISTORY    = 64;
    // unused mode code, behaves as eight regions
    localparam logic [1:0] MODE_SPARE = 2'd3;

    typedef struct packed {
        logic        command;
        logic [31:0] hash_word0;
        logic [31:0] hash_word1;
        logic [31:0] hash_word2;
        logic [31:0] hash_word3;
        logic [14:0] word_address;
    } t_hash_item;

    typedef struct packed {
        logic [31:0] read_data;
        logic        was_present;
    } t_filter_result;

    logic                             i_clk = 1'b0;
    logic                             i_rst_n;
    logic                             i_cfg_we;
    logic [pbfi_pkg::CFG_INDEX_W-1:0] i_cfg_index;
    logic [pbfi_pkg::CFG_DATA_W-1:0]  i_cfg_data;

    pbfi_in_if  in_ch ();
    pbfi_out_if out_ch ();

    partitioned_bitmap_filter_insert #(
        .TOTAL_BITS_LOG2 (TOTAL_LOG2)
    ) uut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_item      (in_ch),
        .o_result    (out_ch)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    logic [31:0]    bitmap_shadow [WORDS];
    logic [1:0]     shadow_mode;
    logic [4:0]     shadow_size;
    logic [14:0]    recent_words [pbfi_pkg::MAX_REGIONS];
    t_filter_result expected_results [$];
    t_hash_item     hash_history [$];
    int             mismatch_count = 0;
    bit             idle_on = 1'b1;
    bit             long_hold_req = 1'b0;

    // sets one bit per region in the shadow bitmap, or reads one word
    function automatic t_filter_result bitmap_update(t_hash_item it);
        logic [31:0]    src [pbfi_pkg::MAX_REGIONS];
        logic [14:0]    word_at [pbfi_pkg::MAX_REGIONS];
        logic [31:0]    bit_at [pbfi_pkg::MAX_REGIONS];
        logic [31:0]    idx;
        int             count_log2;
        int             eff;
        int             stride;
        bit             all_set;
        t_filter_result res;
        res = '0;
        if (it.command == pbfi_pkg::CMD_READ) begin
            res.read_data = bitmap_shadow[it.word_address];
            return res;
        end
        case (shadow_mode)
            pbfi_pkg::MODE_ONE: begin
                count_log2 = 0;
                src[0] = it.hash_word3;
            end
            pbfi_pkg::MODE_FOUR: begin
                count_log2 = 2;
                src[0] = it.hash_word3;
                src[1] = it.hash_word2;
                src[2] = it.hash_word1;
                src[3] = it.hash_word0;
            end
            default: begin
                count_log2 = 3;
                src[0] = it.hash_word0 & pbfi_pkg::HALF_MASK;
                src[1] = it.hash_word0 >> pbfi_pkg::HALF_W;
                src[2] = it.hash_word1 & pbfi_pkg::HALF_MASK;
                src[3] = it.hash_word1 >> pbfi_pkg::HALF_W;
                src[4] = it.hash_word2 & pbfi_pkg::HALF_MASK;
                src[5] = it.hash_word2 >> pbfi_pkg::HALF_W;
                src[6] = it.hash_word3 & pbfi_pkg::HALF_MASK;
                src[7] = it.hash_word3 >> pbfi_pkg::HALF_W;
            end
        endcase
        // clamp so all regions fit, and keep at least one word per region
        eff = shadow_size;
        if (eff > TOTAL_LOG2 - count_log2)
            eff = TOTAL_LOG2 - count_log2;
        if (eff < pbfi_pkg::SIZE_MIN)
            eff = pbfi_pkg::SIZE_MIN;
        stride = 1 << (eff - pbfi_pkg::BIT_W);
        all_set = 1'b1;
        for (int r = 0; r < (1 << count_log2); r++) begin
            idx = src[r] & ((32'd1 << eff) - 32'd1);
            word_at[r] = 15'((r * stride + (idx >> pbfi_pkg::BIT_W)) & (WORDS - 1));
            bit_at[r] = 32'd1 << idx[pbfi_pkg::BIT_W-1:0];
            if ((bitmap_shadow[word_at[r]] & bit_at[r]) == 32'd0)
                all_set = 1'b0;
            recent_words[r] = word_at[r];
        end
        for (int r = 0; r < (1 << count_log2); r++)
            bitmap_shadow[word_at[r]] = bitmap_shadow[word_at[r]] | bit_at[r];
        res.was_present = all_set;
        return res;
    endfunction

    function automatic t_hash_item mk_item(logic cmd, logic [31:0] w0, logic [31:0] w1,
                                           logic [31:0] w2, logic [31:0] w3,
                                           logic [14:0] addr);
        t_hash_item it;
        it.command      = cmd;
        it.hash_word0   = w0;
        it.hash_word1   = w1;
        it.hash_word2   = w2;
        it.hash_word3   = w3;
        it.word_address = addr;
        return it;
    endfunction

    // mostly back to back, some short gaps, a few long ones
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 0;
        if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    function automatic logic [31:0] rand_word();
        int r;
        r = $urandom_range(0, 19);
        if (r == 0)
            return '0;
        if (r == 1)
            return '1;
        return $urandom();
    endfunction

    // reads favor recently touched words, inserts often repeat an old hash
    function automatic t_hash_item random_item();
        t_hash_item  it;
        logic [14:0] addr;
        int          pick;
        pick = $urandom_range(0, 99);
        if (pick < 25) begin
            addr = $urandom_range(0, 1)
                   ? recent_words[$urandom_range(0, pbfi_pkg::MAX_REGIONS - 1)]
                   : 15'($urandom());
            it = mk_item(pbfi_pkg::CMD_READ, $urandom(), $urandom(), $urandom(),
                         $urandom(), addr);
        end else if (pick < 50 && hash_history.size() != 0) begin
            it = hash_history[$urandom_range(0, hash_history.size() - 1)];
            it.word_address = 15'($urandom());
        end else begin
            it = mk_item(pbfi_pkg::CMD_INSERT, rand_word(), rand_word(), rand_word(),
                         rand_word(), 15'($urandom()));
        end
        return it;
    endfunction

    task automatic send_item(t_hash_item it);
        int gap;
        gap = idle_on ? pick_gap() : 0;
        if (gap > 0) begin
            in_ch.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        in_ch.valid        <= 1'b1;
        in_ch.command      <= it.command;
        in_ch.hash_word0   <= it.hash_word0;
        in_ch.hash_word1   <= it.hash_word1;
        in_ch.hash_word2   <= it.hash_word2;
        in_ch.hash_word3   <= it.hash_word3;
        in_ch.word_address <= it.word_address;
        do
            @(posedge i_clk);
        while (!in_ch.ready);
        expected_results.push_back(bitmap_update(it));
        if (it.command == pbfi_pkg::CMD_INSERT) begin
            hash_history.push_back(it);
            if (hash_history.size() > HISTORY)
                void'(hash_history.pop_front());
        end
    endtask

    task automatic wait_for_results();
        in_ch.valid <= 1'b0;
        do
            @(posedge i_clk);
        while (expected_results.size() != 0);
    endtask

    task automatic write_reg(logic [pbfi_pkg::CFG_INDEX_W-1:0] reg_index,
                             logic [pbfi_pkg::CFG_DATA_W-1:0] reg_value);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= reg_index;
        i_cfg_data  <= reg_value;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        if (reg_index == pbfi_pkg::REG_REGION_MODE)
            shadow_mode = reg_value[1:0];
        else
            shadow_size = reg_value;
        @(posedge i_clk);
    endtask

    task automatic set_regions(logic [1:0] mode, logic [4:0] size);
        wait_for_results();
        write_reg(pbfi_pkg::REG_REGION_MODE, pbfi_pkg::CFG_DATA_W'(mode));
        write_reg(pbfi_pkg::REG_REGION_SIZE, size);
    endtask

    // cleared bitmap under the reset settings, first and last words
    task automatic test_reset_state();
        send_item(mk_item(pbfi_pkg::CMD_READ, '0, '0, '0, '0, 15'd0));
        send_item(mk_item(pbfi_pkg::CMD_READ, '0, '0, '0, '0, 15'h7fff));
        send_item(mk_item(pbfi_pkg::CMD_INSERT, '0, '0, '0, '0, 15'd0));
        send_item(mk_item(pbfi_pkg::CMD_INSERT, '0, '0, '0, '0, 15'h7fff));
        send_item(mk_item(pbfi_pkg::CMD_INSERT, '1, '1, '1, '1, 15'd0));
        send_item(mk_item(pbfi_pkg::CMD_READ, '0, '0, '0, '0, 15'd0));
        send_item(mk_item(pbfi_pkg::CMD_READ, '1, '1, '1, '1, 15'd4095));
    endtask

    // each mode at its edges: oversize, undersize, wide eight-region, spare code
    task automatic test_region_extremes();
        set_regions(pbfi_pkg::MODE_ONE, 5'd20);
        send_item(mk_item(pbfi_pkg::CMD_INSERT, '0, '0, '0, '1, 15'd0));
        send_item(mk_item(pbfi_pkg::CMD_READ, '0, '0, '0, '0, 15'h7fff));
        set_regions(pbfi_pkg::MODE_ONE, 5'd31);
        send_item(mk_item(pbfi_pkg::CMD_INSERT, '0, '0, '0, 32'hfff00021, 15'd0));
        send_item(mk_item(pbfi_pkg::CMD_READ, '0, '0, '0, '0, 15'd1));
        set_regions(pbfi_pkg::MODE_EIGHT, 5'd20);
        send_item(mk_item(pbfi_pkg::CMD_INSERT, '1, '1, '1, '1, 15'd0));
        send_item(mk_item(pbfi_pkg::CMD_INSERT, '1, '1, '1, '1, 15'd0));
        send_item(mk_item(pbfi_pkg::CMD_READ, '0, '0, '0, '0, 15'd30719));
        set_regions(MODE_SPARE, 5'd0);
        send_item(mk_item(pbfi_pkg::CMD_INSERT, '1, '1, '1, '1, 15'd0));
        send_item(mk_item(pbfi_pkg::CMD_READ, '0, '0, '0, '0, 15'd7));
        set_regions(pbfi_pkg::MODE_FOUR, 5'd4);
        send_item(mk_item(pbfi_pkg::CMD_INSERT, 32'h20, 32'h20, 32'h20, 32'h20, 15'd0));
    endtask

    task automatic test_random_traffic();
        logic [1:0] modes [6] = '{pbfi_pkg::MODE_EIGHT, pbfi_pkg::MODE_ONE,
                                  pbfi_pkg::MODE_FOUR, pbfi_pkg::MODE_EIGHT,
                                  MODE_SPARE, pbfi_pkg::MODE_ONE};
        logic [4:0] sizes [6] = '{5'd5, 5'd5, 5'd20, 5'd17, 5'd31, 5'd20};
        for (int ph = 0; ph < 8; ph++) begin
            if (ph < 6)
                set_regions(modes[ph], sizes[ph]);
            else
                set_regions(2'($urandom_range(0, 3)), 5'($urandom_range(0, 31)));
            // one phase at full rate on both sides
            idle_on = (ph != 2);
            repeat (70) send_item(random_item());
        end
        idle_on = 1'b1;
    endtask

    // receiver holds off while items keep coming, so the input stalls
    task automatic test_input_backpressure();
        set_regions(pbfi_pkg::MODE_EIGHT, 5'd6);
        idle_on = 1'b0;
        long_hold_req = 1'b1;
        repeat (30) send_item(random_item());
        idle_on = 1'b1;
    endtask

    task automatic test_sender_pause();
        set_regions(pbfi_pkg::MODE_FOUR, 5'd7);
        repeat (20) send_item(random_item());
        wait_for_results();
        repeat (20) send_item(random_item());
    endtask

    // receiver side: random stalls plus the one long hold-off
    initial begin
        int hold_left;
        hold_left = 0;
        out_ch.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (long_hold_req) begin
                long_hold_req = 1'b0;
                hold_left = LONG_HOLD;
            end else if (hold_left == 0 && idle_on) begin
                hold_left = pick_gap();
            end
            if (hold_left > 0) begin
                out_ch.ready <= 1'b0;
                hold_left--;
            end else begin
                out_ch.ready <= 1'b1;
            end
        end
    end

    always @(posedge i_clk) begin
        t_filter_result want;
        if (i_rst_n && out_ch.valid && out_ch.ready) begin
            if (expected_results.size() == 0) begin
                mismatch_count++;
                if (mismatch_count <= 10)
                    $display("unexpected result: read_data %h was_present %b",
                             out_ch.read_data, out_ch.was_present);
            end else begin
                want = expected_results.pop_front();
                if (out_ch.read_data !== want.read_data ||
                    out_ch.was_present !== want.was_present) begin
                    mismatch_count++;
                    if (mismatch_count <= 10)
                        $display("mismatch: read_data exp %h got %h, was_present exp %b got %b",
                                 want.read_data, out_ch.read_data,
                                 want.was_present, out_ch.was_present);
                end
            end
        end
    end

    initial begin
        i_rst_n            <= 1'b0;
        i_cfg_we           <= 1'b0;
        i_cfg_index        <= '0;
        i_cfg_data         <= '0;
        in_ch.valid        <= 1'b0;
        in_ch.command      <= pbfi_pkg::CMD_INSERT;
        in_ch.hash_word0   <= '0;
        in_ch.hash_word1   <= '0;
        in_ch.hash_word2   <= '0;
        in_ch.hash_word3   <= '0;
        in_ch.word_address <= '0;
        shadow_mode = pbfi_pkg::MODE_RESET;
        shadow_size = pbfi_pkg::SIZE_RESET;
        foreach (bitmap_shadow[w])
            bitmap_shadow[w] = '0;
        foreach (recent_words[r])
            recent_words[r] = '0;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_reset_state();
        test_region_extremes();
        test_random_traffic();
        test_input_backpressure();
        test_sender_pause();

        wait_for_results();
        repeat (20) @(posedge i_clk);
        if (mismatch_count == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

    // covers the bitmap clear after reset and every stall with wide margin
    initial begin
        #1000000;
        $display("status: fail");
        $finish;
    end

endmodule
